FILE: hw/rtl/gpc_pkg.sv
// gpc_pkg: shared types and constants for the gait phase clock
// action codes, register indexes, controller command and status structs
// no dependencies
package gpc_pkg;

	localparam int LEG_COUNT    = 6;
	localparam int ACTION_BITS  = 2;
	localparam int CFG_IDX_BITS = 3;

	// action selector carried on the input tuser
	typedef enum logic [ACTION_BITS-1:0] {
		ACT_SET     = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_MIRROR  = 2'd2
	} action_t;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_LEG0_OFFSET = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEG5_OFFSET = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic capture;     // latch the accepted input item
		logic div_start;   // launch the fractional divider
		logic master_upd;  // apply the action to the master phase
		logic emit;        // load the output register
	} gpc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;    // captured item is an advance with non-zero cycle length
		logic div_done;    // divider retires its last step this cycle
		logic out_free;    // output register empty or being drained
	} gpc_sts_t;

endpackage

FILE: hw/rtl/gpc_div.sv
// gpc_div: iterative restoring divider, two quotient bits per cycle
// returns the low PHASE_BITS bits of floor(delta_time * 2^PHASE_BITS / cycle_length)
// depends on nothing outside this file
module gpc_div #(
	parameter int PHASE_BITS = 16,
	parameter int TIME_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TIME_BITS-1:0]  dividend,
	input  logic [TIME_BITS-1:0]  divisor,
	output logic                  done,
	output logic [PHASE_BITS-1:0] quotient
);

	localparam int DW   = ((TIME_BITS + PHASE_BITS + 1) / 2) * 2;
	localparam int ITER = DW / 2;
	localparam int CW   = $clog2(ITER + 1);

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic [TIME_BITS:0]    rem_q;
	logic [DW-1:0]         dvd_q;
	logic [TIME_BITS-1:0]  dsr_q;
	logic [PHASE_BITS-1:0] quo_q;

	logic [TIME_BITS:0]    rem_n;
	logic [DW-1:0]         dvd_n;
	logic [PHASE_BITS-1:0] quo_n;

	assign done     = busy_q && (cnt_q == CW'(ITER - 1));
	assign quotient = quo_q;

	// two restoring steps on the running remainder
	always_comb begin
		logic [TIME_BITS:0] trial;
		rem_n = rem_q;
		dvd_n = dvd_q;
		quo_n = quo_q;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n[TIME_BITS-1:0], dvd_n[DW-1]};
			if (trial >= {1'b0, dsr_q}) begin
				rem_n = trial - {1'b0, dsr_q};
				quo_n = {quo_n[PHASE_BITS-2:0], 1'b1};
			end else begin
				rem_n = trial;
				quo_n = {quo_n[PHASE_BITS-2:0], 1'b0};
			end
			dvd_n = {dvd_n[DW-2:0], 1'b0};
		end
	end

	// step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q  <= cnt_q + CW'(1);
		end
	end

	// remainder, dividend shifter and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= DW'({dividend, {PHASE_BITS{1'b0}}});
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
			quo_q <= quo_n;
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy_q) else $error("divider still busy after last step");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < CW'(ITER))) else $error("divider step count overran");

endmodule

FILE: hw/rtl/gpc_dpath.sv
// gpc_dpath: phase datapath with offset registers, master phase and output register
// uses gpc_pkg and gpc_div
// driven by gpc_ctrl through gpc_cmd_t, reports through gpc_sts_t
module gpc_dpath
	import gpc_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int TIME_BITS  = 24,
	parameter int IN_DW      = 64,
	parameter int OUT_DW     = 112
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gpc_cmd_t                cmd,
	output gpc_sts_t                sts,
	input  logic [IN_DW-1:0]        s_tdata,
	input  logic [ACTION_BITS-1:0]  s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_DW-1:0]       m_tdata,
	output logic [0:0]              m_tuser,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [PHASE_BITS-1:0]   cfg_data
);

	localparam int FLAT_W = (LEG_COUNT + 1) * PHASE_BITS;

	action_t               act_q;
	logic [PHASE_BITS-1:0] arg_q;
	logic [TIME_BITS-1:0]  dt_q;
	logic [TIME_BITS-1:0]  cl_q;

	logic [PHASE_BITS-1:0] offset_q [LEG_COUNT];
	logic [PHASE_BITS-1:0] master_q;
	logic                  neg_q;

	logic                  out_valid_q;
	logic [PHASE_BITS-1:0] out_master_q;
	logic [PHASE_BITS-1:0] out_leg_q [LEG_COUNT];
	logic                  out_bad_q;

	logic                  div_done;
	logic [PHASE_BITS-1:0] div_quo;
	logic                  cl_zero;
	logic [FLAT_W-1:0]     out_flat;

	assign cl_zero = (cl_q == '0);

	gpc_div #(
		.PHASE_BITS(PHASE_BITS),
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dt_q),
		.divisor (cl_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// status back to the controller
	always_comb begin
		sts.need_div = (act_q == ACT_ADVANCE) && !cl_zero;
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || m_tready;
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action_t'(s_tuser);
			arg_q <= s_tdata[PHASE_BITS-1:0];
			dt_q  <= s_tdata[PHASE_BITS+TIME_BITS-1:PHASE_BITS];
			cl_q  <= s_tdata[PHASE_BITS+2*TIME_BITS-1:PHASE_BITS+TIME_BITS];
		end
	end

	// leg offset registers, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEG_COUNT; i++) begin
				offset_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index <= REG_LEG5_OFFSET)) begin
			offset_q[cfg_index - REG_LEG0_OFFSET] <= cfg_data;
		end
	end

	// master phase and mirror flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= '0;
			neg_q    <= 1'b0;
		end else if (cmd.master_upd) begin
			case (act_q)
				ACT_SET: begin
					master_q <= arg_q;
				end
				ACT_ADVANCE: begin
					if (!cl_zero) begin
						master_q <= master_q + div_quo;
					end
				end
				ACT_MIRROR: begin
					master_q <= arg_q - master_q;
					neg_q    <= !neg_q;
				end
				default: begin
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload: master and each leg with its effective offset
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_master_q <= master_q;
			out_bad_q    <= (act_q == ACT_ADVANCE) && cl_zero;
			for (int i = 0; i < LEG_COUNT; i++) begin
				out_leg_q[i] <= neg_q ? (master_q - offset_q[i]) : (master_q + offset_q[i]);
			end
		end
	end

	// pack master first, then legs 0 to 5
	always_comb begin
		out_flat[PHASE_BITS-1:0] = out_master_q;
		for (int i = 0; i < LEG_COUNT; i++) begin
			out_flat[(i+1)*PHASE_BITS +: PHASE_BITS] = out_leg_q[i];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'(out_flat);
	assign m_tuser  = out_bad_q;

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid) else $error("result not presented after emit");
	a_mirror_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.master_upd && (act_q == ACT_MIRROR)) |=> (neg_q != $past(neg_q)))
		else $error("mirror did not toggle offset sign");
	a_bad_keeps_master: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.master_upd && (act_q == ACT_ADVANCE) && cl_zero) |=> $stable(master_q))
		else $error("zero cycle length changed the master phase");

endmodule

FILE: hw/rtl/gpc_ctrl.sv
// gpc_ctrl: item sequencer for the gait phase clock
// accepts one item, runs the divider when needed, updates master, emits result
// uses gpc_pkg
module gpc_ctrl
	import gpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  gpc_sts_t sts,
	output gpc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_DIV,
		ST_MASTER,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	// commands decoded from state, input valid and status
	always_comb begin
		cmd.capture    = (state_q == ST_IDLE) && s_tvalid;
		cmd.div_start  = (state_q == ST_LAUNCH) && sts.need_div;
		cmd.master_upd = (state_q == ST_MASTER);
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: begin
					state_q <= sts.need_div ? ST_DIV : ST_MASTER;
				end
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_MASTER;
				end
				ST_MASTER: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("emit into a full output register");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV)) else $error("divider finished outside its state");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !s_tready) else $error("second item accepted while busy");

endmodule

FILE: hw/rtl/gait_phase_clock.sv
// gait_phase_clock: master gait phase with six offset leg phases
// advance: launch, divide, master, emit states; emit waits for the output register to free
//   the divider retires two quotient bits a cycle over TIME_BITS+PHASE_BITS bits, padded to even
// set, mirror, zero-cycle advance, unused action skip divide; next item only after emit
// output register holds one result while the next item is worked on
// async reset clears master phase, mirror flag, offsets and all control; no clearing pass
module gait_phase_clock
	import gpc_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int TIME_BITS  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// phase_arg, delta_time, cycle_length
	input  logic [((PHASE_BITS+2*TIME_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  logic [ACTION_BITS-1:0]  s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// master_phase, leg0_phase .. leg5_phase
	output logic [(((LEG_COUNT+1)*PHASE_BITS+7)/8)*8-1:0] m_tdata,
	// bad_cycle
	output logic [0:0]              m_tuser,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [PHASE_BITS-1:0]   cfg_data
);

	localparam int IN_DW  = ((PHASE_BITS + 2*TIME_BITS + 7) / 8) * 8;
	localparam int OUT_DW = (((LEG_COUNT + 1) * PHASE_BITS + 7) / 8) * 8;

	gpc_cmd_t cmd;
	gpc_sts_t sts;

	// register writes always taken
	assign cfg_ready = 1'b1;

	gpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gpc_dpath #(
		.PHASE_BITS(PHASE_BITS),
		.TIME_BITS (TIME_BITS),
		.IN_DW     (IN_DW),
		.OUT_DW    (OUT_DW)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
